/* sv/mppo_pkg.sv */
`timescale 1ns / 1ps
// mppo_pkg: shared types, register indexes, mode codes and defaults for the
// perturb-and-observe tracker. No dependencies.
package mppo_pkg;

	localparam int unsigned VOLT_W       = 16;
	localparam int unsigned DUTY_W       = 8;
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned POWER_W      = 2 * VOLT_W;
	localparam int unsigned CFG_INDEX_W  = 3;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [DUTY_W-1:0] DUTY_AT_RESET = DUTY_W'(120);

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUT_VOLTAGE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_IN_VOLTAGE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_CURRENT_LIMIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MIN          = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX          = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_INCREMENT    = 3'd5;

	// result modes
	localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RAMP     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRACK    = 2'd2;

	typedef struct packed {
		logic [VOLT_W-1:0] in_voltage;
		logic [VOLT_W-1:0] in_current;
		logic [VOLT_W-1:0] out_voltage;
	} in_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_out;
		logic [MODE_W-1:0] mode;
	} out_word_t;

	typedef struct packed {
		logic [VOLT_W-1:0] max_out_voltage;
		logic [VOLT_W-1:0] min_in_voltage;
		logic [VOLT_W-1:0] low_current_limit;
		logic [DUTY_W-1:0] duty_min;
		logic [DUTY_W-1:0] duty_max;
		logic [DUTY_W-1:0] duty_increment;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [POWER_W-1:0] power;
	} job_t;

endpackage

/* sv/mppo_front.sv */
`timescale 1ns / 1ps
// mppo_front: accepts sample words, classifies them and forms the input power.
// Depends on mppo_pkg.
module mppo_front (
	input  logic              clk,
	input  logic              arst_n,
	input  mppo_pkg::cfg_t    cfg,
	input  logic              push,
	output logic              full,
	input  mppo_pkg::in_word_t sample,
	output logic              job_valid,
	input  logic              job_full,
	output mppo_pkg::job_t    job
);
	import mppo_pkg::*;

	logic   valid_s1;
	job_t   job_s1;
	logic   load;
	logic   shutdown;
	logic   low_current;
	job_t   job_next;

	// stage frees when empty or when the queue takes its word
	assign load = !valid_s1 || !job_full;
	assign full = !load;

	always_comb begin
		shutdown = (sample.out_voltage >= cfg.max_out_voltage)
			|| (sample.out_voltage > sample.in_voltage)
			|| (sample.in_voltage < cfg.min_in_voltage);
		low_current = sample.in_current < cfg.low_current_limit;
		job_next.power = POWER_W'(sample.in_voltage) * POWER_W'(sample.in_current);
		if (shutdown) begin
			job_next.mode = MODE_SHUTDOWN;
		end else if (low_current) begin
			job_next.mode = MODE_RAMP;
		end else begin
			job_next.mode = MODE_TRACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (load && push) begin
			job_s1 <= job_next;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;

endmodule

/* sv/mppo_queue.sv */
`timescale 1ns / 1ps
// mppo_queue: small register FIFO between front and back.
// No dependencies.
module mppo_queue #(
	parameter int unsigned DATA_W = 34,
	parameter int unsigned DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* sv/mppo_back.sv */
`timescale 1ns / 1ps
// mppo_back: holds duty, direction and last power; steps the duty per job and
// keeps the result word register. Depends on mppo_pkg.
module mppo_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mppo_pkg::cfg_t      cfg,
	input  logic                job_empty,
	input  mppo_pkg::job_t      job,
	output logic                job_take,
	output logic                empty,
	input  logic                pop,
	output mppo_pkg::out_word_t result
);
	import mppo_pkg::*;

	localparam int unsigned SUM_W = DUTY_W + 1;
	localparam int unsigned SD_W  = DUTY_W + 2;

	logic [POWER_W-1:0] last_power_q;
	logic [DUTY_W-1:0]  duty_now_q;
	logic               going_down_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic               rise;
	logic               dir_next;
	logic [DUTY_W-1:0]  ramp_base;
	logic [SUM_W-1:0]   ramp_sum;
	logic [DUTY_W-1:0]  ramp_duty;
	logic signed [SD_W-1:0] trk_step;
	logic signed [SD_W-1:0] trk_max;
	logic signed [SD_W-1:0] trk_min;
	logic [DUTY_W-1:0]  trk_duty;
	logic [DUTY_W-1:0]  duty_next;

	assign job_take = !job_empty && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_comb begin
		// ramp: raise to min, add, cap at max
		ramp_base = (duty_now_q < cfg.duty_min) ? cfg.duty_min : duty_now_q;
		ramp_sum  = {1'b0, ramp_base} + {1'b0, cfg.duty_increment};
		ramp_duty = (ramp_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max
			: ramp_sum[DUTY_W-1:0];

		// tracking: equal power counts as no rise
		rise     = job.power > last_power_q;
		dir_next = rise ? going_down_q : !going_down_q;
		trk_max  = $signed({2'b00, cfg.duty_max});
		trk_min  = $signed({2'b00, cfg.duty_min});
		if (dir_next) begin
			trk_step = $signed({2'b00, duty_now_q}) - $signed({2'b00, cfg.duty_increment});
		end else begin
			trk_step = $signed({2'b00, duty_now_q}) + $signed({2'b00, cfg.duty_increment});
		end
		if (trk_step > trk_max) begin
			trk_step = trk_max;
		end
		// min wins over max; min is never negative so this also floors at zero
		if (trk_step < trk_min) begin
			trk_step = trk_min;
		end
		trk_duty = trk_step[DUTY_W-1:0];

		case (job.mode)
			MODE_SHUTDOWN: duty_next = '0;
			MODE_RAMP:     duty_next = ramp_duty;
			MODE_TRACK:    duty_next = trk_duty;
			default:       duty_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_power_q <= '0;
			duty_now_q   <= DUTY_AT_RESET;
			going_down_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (job_take) begin
				duty_now_q <= duty_next;
				if (job.mode == MODE_TRACK) begin
					going_down_q <= dir_next;
					last_power_q <= job.power;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			out_q.duty_out <= duty_next;
			out_q.mode     <= job.mode;
		end
	end

endmodule

/* sv/mppt_perturb_observe_unit.sv */
`timescale 1ns / 1ps
// mppt_perturb_observe_unit: top level of the perturb-and-observe tracker.
// Depends on mppo_pkg, mppo_front, mppo_queue, mppo_back.
//
// One sample word (input voltage, input current, output voltage) goes in per
// push, one result word (duty byte and mode) comes out per sample, in order.
// The unit takes a new word every cycle while full is low; a word's result is
// visible once it has passed the front register, one queue entry and the result
// register, and later while the result side stalls.
// The front stage decides shutdown / low-current ramp /
// tracking from the sample and the limit registers and forms the 16x16 input
// power product; a QUEUE_DEPTH-deep FIFO separates it from the back stage,
// which owns duty, direction and last power and produces the result word.
// The one-cycle rate is set by the back stage's duty update, which reads the
// duty written by the word before it. Configuration writes take effect at the
// next edge and should land only while no word is in flight. Writes to an
// index beyond the register list are dropped.
module mppt_perturb_observe_unit #(
	parameter int unsigned QUEUE_DEPTH = mppo_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [mppo_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mppo_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample words
	input  logic                               push,
	output logic                               full,
	input  mppo_pkg::in_word_t                 sample,
	// result words
	output logic                               empty,
	input  logic                               pop,
	output mppo_pkg::out_word_t                result
);
	import mppo_pkg::*;

	localparam int unsigned JOB_W = $bits(job_t);

	cfg_t  cfg_q;
	logic  job_valid;
	logic  job_full;
	job_t  job_front;
	logic  job_empty;
	logic  job_take;
	logic [JOB_W-1:0] job_rd;
	job_t  job_back;

	// limit registers; narrow registers take the low data bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_out_voltage   <= '1;
			cfg_q.min_in_voltage    <= '0;
			cfg_q.low_current_limit <= '0;
			cfg_q.duty_min          <= '0;
			cfg_q.duty_max          <= '1;
			cfg_q.duty_increment    <= DUTY_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_OUT_VOLTAGE:   cfg_q.max_out_voltage   <= cfg_data[VOLT_W-1:0];
				REG_MIN_IN_VOLTAGE:    cfg_q.min_in_voltage    <= cfg_data[VOLT_W-1:0];
				REG_LOW_CURRENT_LIMIT: cfg_q.low_current_limit <= cfg_data[VOLT_W-1:0];
				REG_DUTY_MIN:          cfg_q.duty_min          <= cfg_data[DUTY_W-1:0];
				REG_DUTY_MAX:          cfg_q.duty_max          <= cfg_data[DUTY_W-1:0];
				REG_DUTY_INCREMENT:    cfg_q.duty_increment    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// front: classify and multiply
	mppo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.job_valid (job_valid),
		.job_full  (job_full),
		.job       (job_front)
	);

	// decoupling queue of classified words
	mppo_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (job_front),
		.full    (job_full),
		.rd_en   (job_take),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	assign job_back = job_t'(job_rd);

	// back: duty state and result register
	mppo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_back),
		.job_take  (job_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
